// File: sv/mift_pkg.sv
// shared types, codes and helper functions of the masked ip filter table
package mift_pkg;

	localparam logic [1:0] OP_CHECK  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [2:0] ST_CHECKED   = 3'd0;
	localparam logic [2:0] ST_ADDED     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic [31:0] FREE_PATTERN = 32'hffff_ffff;

	typedef struct packed {
		logic load;
		logic read;
		logic hit_act;
		logic miss_act;
		logic shift_run;
		logic shift_end;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic at_end;
		logic drained;
		logic is_remove;
	} sts_t;

	function automatic logic [3:0] octet_mask_of(input logic [31:0] a);
		logic [3:0] m;
		m = '0;
		for (int k = 0; k < 4; k++) begin
			m[k] = (a[8*k +: 8] != 8'd0);
		end
		return m;
	endfunction

	function automatic logic [31:0] expand_mask(input logic [3:0] m);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			r[8*k +: 8] = {8{m[k]}};
		end
		return r;
	endfunction

endpackage

// File: sv/mift_ctrl.sv
// controller state machine: sequences scan, shift and result of one item
module mift_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output mift_pkg::cmd_t cmd,
	input  mift_pkg::sts_t sts
);
	import mift_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.hit_act = 1'b1;
					state_d     = sts.is_remove ? S_SHIFT : S_IDLE;
				end else if (sts.drained) begin
					cmd.miss_act = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.read = !sts.at_end;
				end
			end
			S_SHIFT: begin
				if (sts.drained) begin
					cmd.shift_end = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.shift_run = 1'b1;
					cmd.read      = !sts.at_end;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: sv/mift_datapath.sv
// datapath: entry memory, list count, scan pipeline and result registers
module mift_datapath #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     operation,
	input  logic [31:0]    address,
	input  logic           mute_only,
	input  logic           cfg_we,
	input  logic           ban_mode,
	input  mift_pkg::cmd_t cmd,
	output mift_pkg::sts_t sts,
	output logic           done,
	output logic [2:0]     status,
	output logic           matched,
	output logic           blocked,
	output logic           silenced,
	output logic [9:0]     entry_index
);
	import mift_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	function automatic logic [9:0] idx10(input logic [CW-1:0] v);
		logic [CW+9:0] e;
		e = {10'd0, v};
		return e[9:0];
	endfunction

	logic [32:0]   mem [MAX_ENTRIES];

	logic [1:0]    op_q;
	logic [31:0]   addr_q;
	logic          sil_q;
	logic          ban_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic [32:0]   rd_data_s1;

	logic          done_q;
	logic [2:0]    status_q;
	logic          matched_q;
	logic          blocked_q;
	logic          silenced_q;
	logic [9:0]    index_q;

	logic [31:0]   ent_pat;
	logic          ent_sil;
	logic          match_sel;
	logic          is_add;
	logic          is_remove;
	logic          is_full;
	logic          we;
	logic [AW-1:0] wa;
	logic [32:0]   wd;
	logic [CW-1:0] prev_idx;

	assign ent_pat   = rd_data_s1[31:0];
	assign ent_sil   = rd_data_s1[32];
	assign is_add    = (op_q == OP_ADD);
	assign is_remove = (op_q == OP_REMOVE);
	assign is_full   = (count_q == MAX_CNT);
	assign prev_idx  = rd_idx_s1 - CW'(1);

	always_comb begin
		if (is_add) begin
			match_sel = (ent_pat == FREE_PATTERN);
		end else if (is_remove) begin
			match_sel = (ent_pat == addr_q);
		end else begin
			match_sel = ((addr_q & expand_mask(octet_mask_of(ent_pat))) == ent_pat);
		end
	end

	assign sts.hit       = rd_vld_s1 && match_sel;
	assign sts.at_end    = (rd_idx_q == count_q);
	assign sts.drained   = sts.at_end && !rd_vld_s1;
	assign sts.is_remove = is_remove;

	// single write port: reuse on add, append on add, move down on remove
	always_comb begin
		we = 1'b0;
		wa = rd_idx_s1[AW-1:0];
		wd = {sil_q, addr_q};
		if (cmd.hit_act && is_add) begin
			we = 1'b1;
		end else if (cmd.miss_act && is_add && !is_full) begin
			we = 1'b1;
			wa = count_q[AW-1:0];
		end else if (cmd.shift_run && rd_vld_s1) begin
			we = 1'b1;
			wa = prev_idx[AW-1:0];
			wd = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.read) begin
			rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
			rd_idx_s1  <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ban_q     <= 1'b1;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				ban_q <= ban_mode;
			end
			rd_vld_s1 <= cmd.read;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.read) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end else if (cmd.hit_act && is_remove) begin
				rd_idx_q <= rd_idx_s1 + CW'(1);
			end
			if (cmd.miss_act && is_add && !is_full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.shift_end) begin
				count_q <= count_q - CW'(1);
			end
			done_q <= (cmd.hit_act && !is_remove) || cmd.miss_act || cmd.shift_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			addr_q <= address;
			sil_q  <= mute_only;
		end
		if (cmd.hit_act) begin
			index_q    <= idx10(rd_idx_s1);
			matched_q  <= 1'b0;
			blocked_q  <= 1'b0;
			silenced_q <= 1'b0;
			if (is_add) begin
				status_q <= ST_ADDED;
			end else if (!is_remove) begin
				status_q   <= ST_CHECKED;
				matched_q  <= 1'b1;
				silenced_q <= ent_sil;
				blocked_q  <= ban_q && !ent_sil;
			end
		end else if (cmd.miss_act) begin
			matched_q  <= 1'b0;
			blocked_q  <= 1'b0;
			silenced_q <= 1'b0;
			index_q    <= '0;
			if (is_add) begin
				if (is_full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_ADDED;
					index_q  <= idx10(count_q);
				end
			end else if (is_remove) begin
				status_q <= ST_NOT_FOUND;
			end else begin
				status_q  <= ST_CHECKED;
				blocked_q <= !ban_q;
			end
		end else if (cmd.shift_end) begin
			status_q <= ST_REMOVED;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign matched     = matched_q;
	assign blocked     = blocked_q;
	assign silenced    = silenced_q;
	assign entry_index = index_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count above capacity");

	a_read_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (rd_idx_q < count_q))
		else $error("read beyond end of list");

endmodule

// File: sv/masked_ip_filter_table.sv
// top level of the masked ip filter table: controller plus datapath
// An item is taken when start is high and busy is low; its one result appears for a single
// cycle with done high and cannot be held off by the receiver, so it must be captured then.
// Every item scans the list in order through one memory read port, one entry per cycle.
// With N entries in the list (at most MAX_ENTRIES), a check or add that finds no matching
// entry reads all N entries, and one that stops at the first matching entry k reads no
// further. A remove that hits entry k then moves every later entry down by one, one
// entry per cycle; a remove that finds nothing reads all N entries. The result is shown in
// the first cycle in which the next start can be taken. ban_mode is written through
// cfg_valid/cfg_ready while idle.
module masked_ip_filter_table #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic        mute_only,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        ban_mode,
	output logic        done,
	output logic [2:0]  status,
	output logic        matched,
	output logic        blocked,
	output logic        silenced,
	output logic [9:0]  entry_index
);
	import mift_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = !busy;

	mift_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	mift_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.address      (address),
		.mute_only    (mute_only),
		.cfg_we       (cfg_valid && cfg_ready),
		.ban_mode     (ban_mode),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.matched      (matched),
		.blocked      (blocked),
		.silenced     (silenced),
		.entry_index  (entry_index)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken but block not busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
